FILE: hw/rtl/ial_pkg.sv
// Shared types and constants for the indexed array list block.
// No dependencies; every other file in this block imports this package.
package ial_pkg;

   // List storage geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Beat field widths
   localparam int REQ_TYPE_W = 3;
   localparam int WORD_W     = 32;
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 5;

   // Common width for position against count compares
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_INS_HEAD = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INS_TAIL = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_INS_POS  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_REM_HEAD = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_REM_TAIL = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_REM_POS  = 3'd5;

   // Output register occupancy
   typedef enum logic {
      ST_EMPTY,
      ST_HOLD
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;   // request beat accepted: update list and load response
   } dp_cmd_type;

endpackage

FILE: hw/rtl/ial_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on ial_pkg for field widths.
interface ial_req_if import ial_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic        [REQ_TYPE_W-1:0] req_type;
   logic signed [WORD_W-1:0]     data_word;
   logic        [POS_W-1:0]      position;

   modport source (output valid, output req_type, output data_word, output position,
                   input ready);
   modport sink   (input valid, input req_type, input data_word, input position,
                   output ready);
endinterface

interface ial_rsp_if import ial_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     ok;
   logic signed [WORD_W-1:0] removed_word;
   logic        [COUNT_W-1:0] entry_count;

   modport source (output valid, output ok, output removed_word, output entry_count,
                   input ready);
   modport sink   (input valid, input ok, input removed_word, input entry_count,
                   output ready);
endinterface

FILE: hw/rtl/ial_ctrl.sv
// Handshake controller: tracks the response register and issues execute commands.
// Depends on ial_pkg.
module ial_ctrl import ial_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and outputs; a new beat may enter while the held one drains
   always_comb begin
      state_in  = state_ff;
      rsp_valid = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_EMPTY: begin
            req_ready = 1'b1;
         end
         ST_HOLD: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.exec = req_valid && req_ready;
      if (cmd.exec) begin
         state_in = ST_HOLD;
      end else if (rsp_valid && rsp_ready) begin
         state_in = ST_EMPTY;
      end
   end

endmodule

FILE: hw/rtl/ial_dp.sv
// List datapath: one shift cell per entry, fill count and response register.
// Depends on ial_pkg.
module ial_dp import ial_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   input  logic        [REQ_TYPE_W-1:0] req_type,
   input  logic signed [WORD_W-1:0]     data_word,
   input  logic        [POS_W-1:0]      position,
   output logic                         ok,
   output logic signed [WORD_W-1:0]     removed_word,
   output logic        [COUNT_W-1:0]    entry_count
);

   logic signed [WORD_W-1:0] entries_ff [CAPACITY];
   logic signed [WORD_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     ok_ff, ok_in;
   logic signed [WORD_W-1:0] removed_ff, removed_in;
   logic [COUNT_W-1:0]       entry_count_ff, entry_count_in;

   logic             is_ins, is_rem, full, empty, do_ins, do_rem;
   logic [CMP_W-1:0] at, cnt_cmp;
   logic [IDX_W-1:0] at_idx;

   // Decode the request and pick the target index
   always_comb begin
      cnt_cmp = CMP_W'(count_ff);
      full    = (count_ff == CNT_W'(CAPACITY));
      empty   = (count_ff == '0);
      is_ins  = 1'b0;
      is_rem  = 1'b0;
      at      = '0;
      case (req_type)
         REQ_INS_HEAD: begin is_ins = 1'b1; at = '0; end
         REQ_INS_TAIL: begin is_ins = 1'b1; at = cnt_cmp; end
         REQ_INS_POS:  begin is_ins = 1'b1; at = CMP_W'(position); end
         REQ_REM_HEAD: begin is_rem = 1'b1; at = '0; end
         REQ_REM_TAIL: begin is_rem = 1'b1; at = cnt_cmp - CMP_W'(1); end
         REQ_REM_POS:  begin is_rem = 1'b1; at = CMP_W'(position); end
         default: begin is_ins = 1'b0; is_rem = 1'b0; end
      endcase
      do_ins = is_ins && !full && (at <= cnt_cmp);
      do_rem = is_rem && !empty && (at < cnt_cmp);
      at_idx = at[IDX_W-1:0];
   end

   // Per-cell shift: up above the insert point, down from the remove point
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_ins) begin
            if (CMP_W'(i) == at) begin
               entries_in[i] = data_word;
            end else if (i > 0 && CMP_W'(i) > at && CMP_W'(i) <= cnt_cmp) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_rem) begin
            if (i < CAPACITY - 1 && CMP_W'(i) >= at && CMP_W'(i + 1) < cnt_cmp) begin
               entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   // Count and response values
   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
      ok_in          = do_ins || do_rem;
      removed_in     = do_rem ? entries_ff[at_idx] : '0;
      entry_count_in = COUNT_W'(count_in);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // Cells and response register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         entries_ff     <= entries_in;
         ok_ff          <= ok_in;
         removed_ff     <= removed_in;
         entry_count_ff <= entry_count_in;
      end
   end

   assign ok           = ok_ff;
   assign removed_word = removed_ff;
   assign entry_count  = entry_count_ff;

endmodule

FILE: hw/rtl/indexed_array_list.sv
// Top level of the indexed array list: controller plus list datapath.
// Depends on ial_pkg, ial_if, ial_ctrl and ial_dp.

// A packed, ordered list of up to CAPACITY signed 32-bit words. Each request
// beat inserts or removes at the head, the tail or a given position; every
// cell shifts in parallel, so a request completes in the cycle it is accepted
// and its response beat appears in the next cycle. The response register lets
// a new request enter in the same cycle the held response is taken, giving
// one request per cycle when the response side does not stall. Each response
// carries the success flag, the removed word (zero if none) and the count.
module indexed_array_list import ial_pkg::*; (
   input logic     clock,
   input logic     reset,
   ial_req_if.sink   req,
   ial_rsp_if.source rsp
);

   dp_cmd_type cmd;

   // Handshake and sequencing
   ial_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // List storage and response register
   ial_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_type     (req.req_type),
      .data_word    (req.data_word),
      .position     (req.position),
      .ok           (rsp.ok),
      .removed_word (rsp.removed_word),
      .entry_count  (rsp.entry_count)
   );

endmodule
